>>> sv/cale_pkg.sv
// ============================================================================
// cale_pkg: shared definitions for the compact array list engine
// Sizes, operation and status codes, the result record and the word
// conversion helpers used by the sequencer and the top level.
// ============================================================================
package cale_pkg;

    // Storage sizing.
    localparam int CAPACITY   = 32;
    localparam int WORD_WIDTH = 32;
    localparam int ADDR_W     = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CNT_W      = $clog2(CAPACITY + 1);
    localparam int SLOT_W     = 5;
    localparam int CMP_W      = (CNT_W > SLOT_W) ? CNT_W : SLOT_W;

    // Port field widths.
    localparam int OP_W      = 3;
    localparam int ELEM_W    = 32;
    localparam int STATUS_W  = 2;
    localparam int OUT_CNT_W = 6;

    // A list operation emits at most this many words.
    localparam int MAX_OUT = 32;

    // Operation codes.
    localparam logic [OP_W-1:0] OP_APPEND    = 3'd0;
    localparam logic [OP_W-1:0] OP_DEL_AT    = 3'd1;
    localparam logic [OP_W-1:0] OP_SET_AT    = 3'd2;
    localparam logic [OP_W-1:0] OP_DEL_MATCH = 3'd3;
    localparam logic [OP_W-1:0] OP_REP_MATCH = 3'd4;
    localparam logic [OP_W-1:0] OP_LIST      = 3'd5;

    // Status codes.
    localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd1;
    localparam logic [STATUS_W-1:0] ST_RANGE = 2'd2;
    localparam logic [STATUS_W-1:0] ST_FULL  = 2'd3;

    typedef logic [WORD_WIDTH-1:0] t_word;

    // One result word as it leaves the block.
    typedef struct packed {
        logic signed [ELEM_W-1:0] element;
        logic [STATUS_W-1:0]      status;
        logic [OUT_CNT_W-1:0]     entry_count;
        logic [OUT_CNT_W-1:0]     hits;
        logic                     element_valid;
        logic                     last;
    } t_result;

    // Sign-extend a 32-bit operand and cut it to the stored word width.
    function automatic t_word to_word(input logic [ELEM_W-1:0] v);
        t_word y;
        for (int k = 0; k < WORD_WIDTH; k++) begin
            y[k] = (k < ELEM_W) ? v[k] : v[ELEM_W-1];
        end
        return y;
    endfunction

    // Sign-extend a stored word and cut it to the 32-bit element field.
    function automatic logic [ELEM_W-1:0] from_word(input t_word w);
        logic [ELEM_W-1:0] y;
        for (int k = 0; k < ELEM_W; k++) begin
            y[k] = (k < WORD_WIDTH) ? w[k] : w[WORD_WIDTH-1];
        end
        return y;
    endfunction

endpackage

>>> sv/cale_ram.sv
// ============================================================================
// cale_ram: simple dual-port synchronous RAM
// One write port and one read port; read data is registered, so it appears
// in the cycle after the read enable.
// ============================================================================
module cale_ram #(
    parameter int DEPTH  = 32,
    parameter int WIDTH  = 32,
    parameter int ADDR_W = 5
) (
    input  logic              i_clk,
    input  logic              i_we,
    input  logic [ADDR_W-1:0] i_waddr,
    input  logic [WIDTH-1:0]  i_wdata,
    input  logic              i_re,
    input  logic [ADDR_W-1:0] i_raddr,
    output logic [WIDTH-1:0]  o_rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
    end

    // Registered read port.
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

>>> sv/cale_seq.sv
// ============================================================================
// cale_seq: operation sequencer for the compact array list engine
// Decodes one operation at a time and walks the entry RAM with a
// read-modify-write pipeline: append and set-at write once, delete and the
// matching operations stream through the entries, list reads one entry per
// output word.
// ============================================================================
module cale_seq (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_in_valid,
    output logic                             o_in_ready,
    input  logic [cale_pkg::OP_W-1:0]        i_op,
    input  logic signed [cale_pkg::ELEM_W-1:0] i_operand_word,
    input  logic [cale_pkg::SLOT_W-1:0]      i_slot,
    input  logic signed [cale_pkg::ELEM_W-1:0] i_replacement,
    input  logic                             i_out_free,
    output logic                             o_res_load,
    output cale_pkg::t_result                o_res
);

    localparam int AW = cale_pkg::ADDR_W;
    localparam int CW = cale_pkg::CNT_W;

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_SCAN  = 3'd1;
    localparam logic [2:0] S_DONE  = 3'd2;
    localparam logic [2:0] S_LRD   = 3'd3;
    localparam logic [2:0] S_LWAIT = 3'd4;

    // Control state.
    logic [2:0]    r_state, n_state;
    logic [CW-1:0] r_fill,  n_fill;
    logic          r_pv,    n_pv;

    // Per-operation working registers.
    logic [cale_pkg::OP_W-1:0]     r_mode,   n_mode;
    cale_pkg::t_word               r_word,   n_word;
    cale_pkg::t_word               r_rep,    n_rep;
    logic [CW-1:0]                 r_rd,     n_rd;
    logic [CW-1:0]                 r_wr,     n_wr;
    logic [CW-1:0]                 r_lim,    n_lim;
    logic [CW-1:0]                 r_hits,   n_hits;
    logic [AW-1:0]                 r_pidx,   n_pidx;
    logic [cale_pkg::STATUS_W-1:0] r_status, n_status;

    // RAM port signals.
    logic            mem_we;
    logic [AW-1:0]   mem_waddr;
    cale_pkg::t_word mem_wdata;
    logic            mem_re;
    logic [AW-1:0]   mem_raddr;
    cale_pkg::t_word mem_rdata;

    logic          slot_bad;
    logic          issue;
    logic          match;
    logic          list_last;
    logic [CW-1:0] rd_inc;

    cale_ram #(
        .DEPTH  (cale_pkg::CAPACITY),
        .WIDTH  (cale_pkg::WORD_WIDTH),
        .ADDR_W (AW)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_re    (mem_re),
        .i_raddr (mem_raddr),
        .o_rdata (mem_rdata)
    );

    assign o_in_ready = (r_state == S_IDLE);
    assign slot_bad   = cale_pkg::CMP_W'(i_slot) >= cale_pkg::CMP_W'(r_fill);
    assign issue      = (r_rd < r_fill);
    assign match      = (mem_rdata == r_word);
    assign rd_inc     = r_rd + 1'b1;
    assign list_last  = (rd_inc == r_lim);

    // Next-state and RAM access logic.
    always_comb begin
        n_state    = r_state;
        n_fill     = r_fill;
        n_pv       = r_pv;
        n_mode     = r_mode;
        n_word     = r_word;
        n_rep      = r_rep;
        n_rd       = r_rd;
        n_wr       = r_wr;
        n_lim      = r_lim;
        n_hits     = r_hits;
        n_pidx     = r_pidx;
        n_status   = r_status;
        mem_we     = 1'b0;
        mem_waddr  = '0;
        mem_wdata  = '0;
        mem_re     = 1'b0;
        mem_raddr  = '0;
        o_res_load = 1'b0;
        o_res      = '0;

        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_mode   = i_op;
                    n_word   = cale_pkg::to_word(i_operand_word);
                    n_rep    = cale_pkg::to_word(i_replacement);
                    n_hits   = '0;
                    n_status = cale_pkg::ST_OK;
                    n_pv     = 1'b0;
                    n_state  = S_DONE;
                    unique case (i_op) inside
                        cale_pkg::OP_APPEND: begin
                            if (r_fill == CW'(cale_pkg::CAPACITY)) begin
                                n_status = cale_pkg::ST_FULL;
                            end else begin
                                mem_we    = 1'b1;
                                mem_waddr = r_fill[AW-1:0];
                                mem_wdata = cale_pkg::to_word(i_operand_word);
                                n_fill    = r_fill + 1'b1;
                            end
                        end
                        cale_pkg::OP_DEL_AT: begin
                            if (r_fill == '0) begin
                                n_status = cale_pkg::ST_EMPTY;
                            end else if (slot_bad) begin
                                n_status = cale_pkg::ST_RANGE;
                            end else begin
                                n_rd    = CW'(i_slot) + 1'b1;
                                n_wr    = CW'(i_slot);
                                n_state = S_SCAN;
                            end
                        end
                        cale_pkg::OP_SET_AT: begin
                            if (slot_bad) begin
                                n_status = cale_pkg::ST_RANGE;
                            end else begin
                                mem_we    = 1'b1;
                                mem_waddr = AW'(i_slot);
                                mem_wdata = cale_pkg::to_word(i_operand_word);
                            end
                        end
                        cale_pkg::OP_DEL_MATCH, cale_pkg::OP_REP_MATCH: begin
                            n_rd    = '0;
                            n_wr    = '0;
                            n_state = S_SCAN;
                        end
                        cale_pkg::OP_LIST: begin
                            if (r_fill == '0) begin
                                n_status = cale_pkg::ST_EMPTY;
                            end else begin
                                n_rd    = '0;
                                n_lim   = (int'(r_fill) > cale_pkg::MAX_OUT) ?
                                          CW'(cale_pkg::MAX_OUT) : r_fill;
                                n_state = S_LRD;
                            end
                        end
                        default: begin
                            // Undefined codes complete with a plain ok result.
                            n_status = cale_pkg::ST_OK;
                        end
                    endcase
                end
            end

            S_SCAN: begin
                // Read side: one entry per cycle until the fill count.
                if (issue) begin
                    mem_re    = 1'b1;
                    mem_raddr = r_rd[AW-1:0];
                    n_rd      = rd_inc;
                    n_pidx    = r_rd[AW-1:0];
                end
                n_pv = issue;

                // Write side: act on the entry read in the previous cycle.
                // The write index never reaches the entry being read.
                if (r_pv) begin
                    case (r_mode)
                        cale_pkg::OP_DEL_AT: begin
                            mem_we    = 1'b1;
                            mem_waddr = r_wr[AW-1:0];
                            mem_wdata = mem_rdata;
                            n_wr      = r_wr + 1'b1;
                        end
                        cale_pkg::OP_DEL_MATCH: begin
                            if (match) begin
                                n_hits = r_hits + 1'b1;
                            end else begin
                                mem_we    = 1'b1;
                                mem_waddr = r_wr[AW-1:0];
                                mem_wdata = mem_rdata;
                                n_wr      = r_wr + 1'b1;
                            end
                        end
                        cale_pkg::OP_REP_MATCH: begin
                            if (match) begin
                                mem_we    = 1'b1;
                                mem_waddr = r_pidx;
                                mem_wdata = r_rep;
                                n_hits    = r_hits + 1'b1;
                            end
                        end
                        default: begin
                            n_hits = r_hits;
                        end
                    endcase
                end

                // Pipeline drained: settle the new fill count.
                if (!issue && !r_pv) begin
                    case (r_mode)
                        cale_pkg::OP_DEL_AT:    n_fill = r_fill - 1'b1;
                        cale_pkg::OP_DEL_MATCH: n_fill = r_wr;
                        default:                n_fill = r_fill;
                    endcase
                    n_state = S_DONE;
                end
            end

            S_DONE: begin
                // Single status word once the output register is free.
                if (i_out_free) begin
                    o_res_load              = 1'b1;
                    o_res.element           = '0;
                    o_res.status            = r_status;
                    o_res.entry_count       = cale_pkg::OUT_CNT_W'(r_fill);
                    o_res.hits              = cale_pkg::OUT_CNT_W'(r_hits);
                    o_res.element_valid     = 1'b0;
                    o_res.last              = 1'b1;
                    n_state                 = S_IDLE;
                end
            end

            S_LRD: begin
                // Fetch the next entry only when its output slot is free.
                if (i_out_free) begin
                    mem_re    = 1'b1;
                    mem_raddr = r_rd[AW-1:0];
                    n_state   = S_LWAIT;
                end
            end

            S_LWAIT: begin
                o_res_load          = 1'b1;
                o_res.element       = cale_pkg::from_word(mem_rdata);
                o_res.status        = cale_pkg::ST_OK;
                o_res.entry_count   = cale_pkg::OUT_CNT_W'(r_fill);
                o_res.hits          = '0;
                o_res.element_valid = 1'b1;
                o_res.last          = list_last;
                n_rd                = rd_inc;
                n_state             = list_last ? S_IDLE : S_LRD;
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_fill  <= '0;
            r_pv    <= 1'b0;
        end else begin
            r_state <= n_state;
            r_fill  <= n_fill;
            r_pv    <= n_pv;
        end
    end

    // Working registers.
    always_ff @(posedge i_clk) begin
        r_mode   <= n_mode;
        r_word   <= n_word;
        r_rep    <= n_rep;
        r_rd     <= n_rd;
        r_wr     <= n_wr;
        r_lim    <= n_lim;
        r_hits   <= n_hits;
        r_pidx   <= n_pidx;
        r_status <= n_status;
    end

endmodule

>>> sv/compact_array_list_engine_core.sv
// ============================================================================
// compact_array_list_engine_core: packed list of signed words
// Top level: operation sequencer with its entry RAM, and the output register.
// ============================================================================
// Usage:
//   The input channel (i_in_valid / o_in_ready) takes one operation word:
//   append, delete at, set at, delete matching, replace matching or list.
//   The output channel (o_out_valid / i_out_ready) returns one result word
//   per operation, or one word per entry for a list of a non-empty store,
//   with o_last marking the final word of the operation.
//   Operations run one at a time. Append, set at, error cases and undefined
//   codes go straight to their single status word. Delete at streams the
//   entries after the slot, and the matching operations all entries,
//   through the single RAM read port at one entry per cycle. List fetches
//   each entry only once the output register is free, one entry per output
//   word. A new operation is accepted as soon as the previous one has handed
//   its last word to the output register.
//   If the receiver stalls, the output register holds its word and the
//   sequencer waits before producing the next one; nothing is dropped.
//   Reset (synchronous, active low) empties the list; the entry RAM is not
//   cleared and needs no clearing pass, since only written entries are read.
// ============================================================================
module compact_array_list_engine_core (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_in_valid,
    output logic                                o_in_ready,
    input  logic [cale_pkg::OP_W-1:0]           i_op,
    input  logic signed [cale_pkg::ELEM_W-1:0]  i_operand_word,
    input  logic [cale_pkg::SLOT_W-1:0]         i_slot,
    input  logic signed [cale_pkg::ELEM_W-1:0]  i_replacement,
    output logic                                o_out_valid,
    input  logic                                i_out_ready,
    output logic signed [cale_pkg::ELEM_W-1:0]  o_element,
    output logic [cale_pkg::STATUS_W-1:0]       o_status,
    output logic [cale_pkg::OUT_CNT_W-1:0]      o_entry_count,
    output logic [cale_pkg::OUT_CNT_W-1:0]      o_hits,
    output logic                                o_element_valid,
    output logic                                o_last
);

    logic              r_ov;
    cale_pkg::t_result r_res;
    cale_pkg::t_result res;
    logic              res_load;
    logic              out_free;

    assign out_free = !r_ov || i_out_ready;

    cale_seq u_seq (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_ready     (o_in_ready),
        .i_op           (i_op),
        .i_operand_word (i_operand_word),
        .i_slot         (i_slot),
        .i_replacement  (i_replacement),
        .i_out_free     (out_free),
        .o_res_load     (res_load),
        .o_res          (res)
    );

    // Output word valid flag.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
        end else if (res_load) begin
            r_ov <= 1'b1;
        end else if (i_out_ready) begin
            r_ov <= 1'b0;
        end
    end

    // Output word payload.
    always_ff @(posedge i_clk) begin
        if (res_load) begin
            r_res <= res;
        end
    end

    assign o_out_valid     = r_ov;
    assign o_element       = r_res.element;
    assign o_status        = r_res.status;
    assign o_entry_count   = r_res.entry_count;
    assign o_hits          = r_res.hits;
    assign o_element_valid = r_res.element_valid;
    assign o_last          = r_res.last;

`ifndef SYNTHESIS
    // The sequencer never overwrites a word that has not been taken.
    a_load_when_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        res_load |-> (!r_ov || i_out_ready))
        else $error("result loaded over a pending output word");

    // A list entry always carries an ok status and no hit count.
    a_entry_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ov && r_res.element_valid) |->
            (r_res.status == cale_pkg::ST_OK && r_res.hits == '0))
        else $error("list entry with non-ok status or hits");

    // A status word is a single, final word with a zero element.
    a_status_word: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ov && !r_res.element_valid) |-> (r_res.last && r_res.element == '0))
        else $error("status word not final or element not zero");

    // No new operation is taken while the sequencer produces words.
    a_no_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        res_load |-> !o_in_ready)
        else $error("operation accepted while results are pending");
`endif

endmodule
